// ----- hdl/multiplexed_seven_segment_scanner_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the multiplexed seven-segment scanner
// Shared property forms that the scanner RTL uses for its checks.
// ----------------------------------------------------------------------------
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MSS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mss_pkg.sv -----
// ----------------------------------------------------------------------------
// Scanner package
// Field widths, codes, configuration type and the character table.
// ----------------------------------------------------------------------------
package mss_pkg;

  localparam int unsigned MAX_DIGITS_DEF = 4;
  localparam int unsigned FUNC_W         = 2;
  localparam int unsigned INDEX_W        = 2;
  localparam int unsigned CODE_W         = 5;
  localparam int unsigned SEG_W          = 7;
  localparam int unsigned DIG_LINES      = 4;
  localparam int unsigned COUNT_W        = 3;
  localparam int unsigned NUM_CODES      = 18;
  localparam int unsigned APB_DATA_W     = 32;
  localparam int unsigned APB_ADDR_W     = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET   = 2'd0,
    FUNC_SCAN  = 2'd1,
    FUNC_BLANK = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_DIGIT_COUNT = 2'd0,
    REG_SEG_INV     = 2'd1,
    REG_DIG_INV     = 2'd2
  } reg_e;

  typedef struct packed {
    logic [COUNT_W-1:0] digit_count;
    logic               segments_inverted;
    logic               digits_inverted;
  } cfg_t;

  function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
    logic [SEG_W-1:0] pat;
    case (code)
      5'd0:    pat = 7'h3F;
      5'd1:    pat = 7'h06;
      5'd2:    pat = 7'h5B;
      5'd3:    pat = 7'h4F;
      5'd4:    pat = 7'h66;
      5'd5:    pat = 7'h6D;
      5'd6:    pat = 7'h7D;
      5'd7:    pat = 7'h07;
      5'd8:    pat = 7'h7F;
      5'd9:    pat = 7'h6F;
      5'd10:   pat = 7'h00;
      5'd11:   pat = 7'h74;
      5'd12:   pat = 7'h39;
      5'd13:   pat = 7'h79;
      5'd14:   pat = 7'h71;
      5'd15:   pat = 7'h50;
      5'd16:   pat = 7'h63;
      5'd17:   pat = 7'h40;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

// ----- hdl/mss_channels.sv -----
// ----------------------------------------------------------------------------
// Scanner channels
// Valid/ready interfaces for the command items and the line level items.
// ----------------------------------------------------------------------------
interface mss_in_if;
  logic                       valid;
  logic                       ready;
  logic [mss_pkg::FUNC_W-1:0]  func;
  logic [mss_pkg::INDEX_W-1:0] digit_index;
  logic [mss_pkg::CODE_W-1:0]  char_code;

  modport source(output valid, func, digit_index, char_code, input ready);
  modport sink(input valid, func, digit_index, char_code, output ready);
endinterface

interface mss_out_if;
  logic                          valid;
  logic                          ready;
  logic [mss_pkg::SEG_W-1:0]     segment_lines;
  logic [mss_pkg::DIG_LINES-1:0] digit_lines;

  modport source(output valid, segment_lines, digit_lines, input ready);
  modport sink(input valid, segment_lines, digit_lines, output ready);
endinterface

// ----- hdl/mss_regs.sv -----
// ----------------------------------------------------------------------------
// Scanner configuration registers
// APB register file holding digit count and the two polarity bits.
// ----------------------------------------------------------------------------
module mss_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mss_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [mss_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [mss_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output mss_pkg::cfg_t                      cfg_o
);

  mss_pkg::cfg_t cfg_q, cfg_d;
  mss_pkg::reg_e sel;
  logic          wr_en;

  assign sel    = mss_pkg::reg_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        mss_pkg::REG_DIGIT_COUNT: cfg_d.digit_count = pwdata[mss_pkg::COUNT_W-1:0];
        mss_pkg::REG_SEG_INV:     cfg_d.segments_inverted = pwdata[0];
        mss_pkg::REG_DIG_INV:     cfg_d.digits_inverted = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (sel)
      mss_pkg::REG_DIGIT_COUNT: prdata[mss_pkg::COUNT_W-1:0] = cfg_q.digit_count;
      mss_pkg::REG_SEG_INV:     prdata[0] = cfg_q.segments_inverted;
      mss_pkg::REG_DIG_INV:     prdata[0] = cfg_q.digits_inverted;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hdl/multiplexed_seven_segment_scanner.sv -----
// ----------------------------------------------------------------------------
// Multiplexed seven-segment scanner
// Stores character codes per digit and drives segment and digit lines.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake      Payload
// in_i     in   valid/ready    func, digit_index, char_code
// out_o    out  valid/ready    segment_lines, digit_lines
// apb      in   psel/penable   paddr, pwdata (prdata back)
//
// Each item's result is registered and is ready in the cycle after the item is taken.
// The line registers themselves form the result register, so a new item is
// accepted whenever no result waits or the waiting one is taken that cycle.
// Reset clears the codes, the pointer and the line levels; there is no
// clearing pass.
`include "multiplexed_seven_segment_scanner_defines.svh"

module multiplexed_seven_segment_scanner #(
  parameter int unsigned MAX_DIGITS = mss_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  mss_in_if.sink                         in_i,
  mss_out_if.source                      out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mss_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mss_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mss_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int unsigned PTR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned CMP_W = (CNT_W > mss_pkg::COUNT_W) ? CNT_W : mss_pkg::COUNT_W;

  mss_pkg::cfg_t                 cfg;
  logic [mss_pkg::CODE_W-1:0]    codes_q [MAX_DIGITS];
  logic [mss_pkg::CODE_W-1:0]    codes_d [MAX_DIGITS];
  logic [PTR_W-1:0]              ptr_q, ptr_d, ptr_cur;
  logic [mss_pkg::SEG_W-1:0]     seg_q, seg_d;
  logic [mss_pkg::DIG_LINES-1:0] dig_q, dig_d;
  logic                          out_valid_q, out_valid_d;
  logic                          in_fire;
  logic [CMP_W-1:0]              count_ext, eff_count, ptr_ext;
  mss_pkg::func_e                func;

  mss_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_i.ready          = !out_valid_q || out_o.ready;
  assign in_fire             = in_i.valid && in_i.ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.segment_lines = seg_q;
  assign out_o.digit_lines   = dig_q;
  assign func                = mss_pkg::func_e'(in_i.func);

  assign count_ext = CMP_W'(cfg.digit_count);
  assign eff_count = (count_ext > CMP_W'(MAX_DIGITS)) ? CMP_W'(MAX_DIGITS) : count_ext;
  assign ptr_cur   = (CMP_W'(ptr_q) >= eff_count) ? '0 : ptr_q;
  assign ptr_ext   = CMP_W'(ptr_cur);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_comb begin
    codes_d = codes_q;
    ptr_d   = ptr_q;
    seg_d   = seg_q;
    dig_d   = dig_q;
    if (in_fire) begin
      case (func)
        mss_pkg::FUNC_SET: begin
          if (32'(in_i.char_code) < mss_pkg::NUM_CODES) begin
            for (int i = 0; i < int'(MAX_DIGITS); i++) begin
              if (i == int'(in_i.digit_index)) begin
                codes_d[i] = in_i.char_code;
              end
            end
          end
        end
        mss_pkg::FUNC_SCAN: begin
          if (eff_count != '0) begin
            for (int i = 0; i < int'(mss_pkg::DIG_LINES); i++) begin
              if (CMP_W'(i) < eff_count) begin
                dig_d[i] = cfg.digits_inverted;
              end
              if (CMP_W'(i) == ptr_ext) begin
                dig_d[i] = !cfg.digits_inverted;
              end
            end
            seg_d = mss_pkg::glyph(codes_q[ptr_cur])
                    ^ {mss_pkg::SEG_W{cfg.segments_inverted}};
            ptr_d = ((ptr_ext + CMP_W'(1)) == eff_count) ? '0 : ptr_cur + PTR_W'(1);
          end
        end
        mss_pkg::FUNC_BLANK: begin
          for (int i = 0; i < int'(mss_pkg::DIG_LINES); i++) begin
            if (CMP_W'(i) < eff_count) begin
              dig_d[i] = cfg.digits_inverted;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_DIGITS); i++) begin
        codes_q[i] <= '0;
      end
      ptr_q       <= '0;
      seg_q       <= '0;
      dig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      codes_q     <= codes_d;
      ptr_q       <= ptr_d;
      seg_q       <= seg_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MSS_ASSERT_NEXT(a_set_keeps_lines, clk_i, rst_ni, in_fire && func == mss_pkg::FUNC_SET, $stable(seg_q) && $stable(dig_q), "set item changed the line levels")
  `MSS_ASSERT_SAME(a_no_accept_when_full, clk_i, rst_ni, out_valid_q && !out_o.ready, !in_i.ready, "item accepted while a result was waiting")
  `MSS_ASSERT_NEXT(a_idle_scan_holds, clk_i, rst_ni, in_fire && func == mss_pkg::FUNC_SCAN && eff_count == '0, $stable(ptr_q) && $stable(seg_q) && $stable(dig_q), "scan with no digits changed state")

endmodule
